// ===== rtl/core/poly_voice_allocator_core_assert.svh =====
// Assertion macros for the voice allocator core.
// Used by the top level; needs clk and rst_n in the including scope.
`ifndef POLY_VOICE_ALLOCATOR_CORE_ASSERT_SVH
`define POLY_VOICE_ALLOCATOR_CORE_ASSERT_SVH

// expression holds at every edge out of reset
`define PVA_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// same-cycle implication
`define PVA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PVA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/pva_pkg.sv =====
// Shared types and codes for the voice allocator.
// No dependencies; used by the voice memory and the top level.
`default_nettype none

package pva_pkg;

  localparam int VOICES_DEF = 16;
  localparam int NOTES_DEF  = 128;

  localparam logic [2:0] OP_NOTE_ON    = 3'd0;
  localparam logic [2:0] OP_NOTE_OFF   = 3'd1;
  localparam logic [2:0] OP_STOP       = 3'd2;
  localparam logic [2:0] OP_PEDAL_DOWN = 3'd3;
  localparam logic [2:0] OP_PEDAL_UP   = 3'd4;

  localparam logic [2:0] ACT_START     = 3'd0;
  localparam logic [2:0] ACT_RETRIG    = 3'd1;
  localparam logic [2:0] ACT_STEAL_REL = 3'd2;
  localparam logic [2:0] ACT_STEAL_OLD = 3'd3;
  localparam logic [2:0] ACT_RELEASE   = 3'd4;
  localparam logic [2:0] ACT_STOP      = 3'd5;

  localparam logic [7:0] FREE_MARK = 8'h80;

  typedef struct packed {
    logic [7:0]  note;
    logic [31:0] stamp;
    logic        rel;
  } voice_ent_t;

  localparam voice_ent_t VOICE_RST = '{note: FREE_MARK, stamp: 32'd0, rel: 1'b0};

  typedef struct packed {
    logic       en;
    voice_ent_t ent;
  } voice_wr_t;

  typedef struct packed {
    logic [3:0] voice;
    logic [2:0] action;
    logic [6:0] note;
    logic [6:0] velocity;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUST_RD,
    ST_SUST_CHK,
    ST_SCAN,
    ST_APPLY,
    ST_FLUSH
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/pva_in_if.sv =====
// Input channel of the voice allocator: one note event per beat.
// No dependencies.
`default_nettype none

interface pva_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [6:0] note;
  logic [6:0] velocity;

  modport source (output valid, output operation, output note, output velocity, input ready);
  modport sink   (input valid, input operation, input note, input velocity, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/pva_out_if.sv =====
// Result channel of the voice allocator: one voice action per beat.
// No dependencies.
`default_nettype none

interface pva_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] voice;
  logic [2:0] action;
  logic [6:0] note_out;
  logic [6:0] velocity_out;
  logic       last;

  modport source (output valid, output voice, output action, output note_out,
                  output velocity_out, output last, input ready);
  modport sink   (input valid, input voice, input action, input note_out,
                  input velocity_out, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/pva_voice_mem.sv =====
// Voice state memory: note, stamp and release flag per voice, registered read.
// Depends on pva_pkg. Per-entry valid bits give the reset value until written.
`default_nettype none

module pva_voice_mem import pva_pkg::*; #(
  parameter int VOICES = VOICES_DEF,
  localparam int VAW = (VOICES > 1) ? $clog2(VOICES) : 1
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic [VAW-1:0] rd_addr,
  output voice_ent_t          rd_data,
  input  wire logic [VAW-1:0] wr_addr,
  input  wire voice_wr_t      wr
);

  voice_ent_t        mem [VOICES];
  voice_ent_t        rd_q_r;
  logic              rd_vq_r;
  logic [VOICES-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= wr.ent;
    end
    rd_q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      rd_vq_r <= 1'b0;
    end else begin
      if (wr.en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      rd_vq_r <= vld_r[rd_addr];
    end
  end

  assign rd_data = rd_vq_r ? rd_q_r : VOICE_RST;

endmodule

`default_nettype wire

// ===== rtl/core/poly_voice_allocator_core.sv =====
// Polyphonic voice allocator top level: sequencer, sustain memory, output stage.
// Depends on pva_pkg, pva_in_if, pva_out_if, pva_voice_mem and the assert macros.
//
// Use:
//   in_ch  carries note events (operation, note, velocity); a beat is taken
//          only while the sequencer is idle.
//   out_ch carries voice actions; the final beat of an event has last set.
//   Every event that is not ignored advances a 32-bit stamp. Note on, stop
//   and note off with the pedal up scan all voices through the voice memory,
//   one read per cycle, then write back the chosen voice if there is a result.
// Pedal up: the sustain memory is read note by note and each sustained note
//   costs one voice scan. Pedal down and ignored codes need no scan.
// Reset: voices read as free, sustain flags cleared by valid bits, pedal up,
//   no clearing pass needed.
// Stall: one result waits in a hold register and one in the output register;
//   if both are full and the receiver stalls, the sequencer waits to write.
`default_nettype none

module poly_voice_allocator_core import pva_pkg::*; #(
  parameter int VOICES = VOICES_DEF,
  parameter int NOTES  = NOTES_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  pva_in_if.sink   in_ch,
  pva_out_if.source out_ch
);

`include "poly_voice_allocator_core_assert.svh"

  localparam int VAW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int VCW = $clog2(VOICES + 1);
  localparam int SAW = (NOTES > 1) ? $clog2(NOTES) : 1;
  localparam int SCW = $clog2(NOTES + 1);

  // sequencer and event registers
  state_t          state_r, state_nxt;
  logic [2:0]      op_r, op_nxt;
  logic [6:0]      vel_r, vel_nxt;
  logic [6:0]      scan_note_r, scan_note_nxt;
  logic [31:0]     stamp_r, stamp_nxt;
  logic            pedal_r, pedal_nxt;
  logic [SCW-1:0]  sust_idx_r, sust_idx_nxt;

  // scan pipeline and trackers
  logic [VCW-1:0]  rd_idx_r, rd_idx_nxt;
  logic            chk_vld_r, chk_vld_nxt;
  logic [VAW-1:0]  chk_idx_r, chk_idx_nxt;
  logic            match_vld_r, match_vld_nxt;
  logic [VAW-1:0]  match_idx_r, match_idx_nxt;
  logic            free_vld_r, free_vld_nxt;
  logic [VAW-1:0]  free_idx_r, free_idx_nxt;
  logic            rel_vld_r, rel_vld_nxt;
  logic [VAW-1:0]  rel_idx_r, rel_idx_nxt;
  logic [31:0]     rel_age_r, rel_age_nxt;
  logic            all_vld_r, all_vld_nxt;
  logic [VAW-1:0]  all_idx_r, all_idx_nxt;
  logic [31:0]     all_age_r, all_age_nxt;

  // result hold and output stage
  logic            hold_vld_r, hold_vld_nxt;
  result_t         hold_r, hold_nxt;
  logic            out_valid_r, out_valid_nxt;
  result_t         out_r, out_nxt;
  logic            out_last_r, out_last_nxt;

  // sustain memory with valid overlay
  logic            sust_mem [NOTES];
  logic [NOTES-1:0] sust_vld_r;
  logic            sust_q_r;
  logic            sust_vq_r;
  logic            sust_we;
  logic            sust_wd;
  logic            sust_clr;
  logic [SAW-1:0]  sust_waddr;
  logic [SAW-1:0]  sust_raddr;
  logic            sust_bit;

  // voice memory port
  logic [VAW-1:0]  vm_raddr;
  logic [VAW-1:0]  vm_waddr;
  voice_wr_t       vm_wr;
  voice_ent_t      vm_rd;

  // helpers
  logic            in_fire;
  logic            acc_ok;
  logic            out_busy;
  logic            scan_issue;
  logic            apply_go;
  logic            has_res;
  logic [VAW-1:0]  sel_idx;
  logic [2:0]      sel_act;
  logic [31:0]     age;

  pva_voice_mem #(.VOICES(VOICES)) u_voice_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (vm_raddr),
    .rd_data (vm_rd),
    .wr_addr (vm_waddr),
    .wr      (vm_wr)
  );

  assign in_fire  = in_ch.valid && (state_r == ST_IDLE);
  // unknown codes and out-of-range notes are dropped without a stamp step
  assign acc_ok   = (in_ch.operation <= OP_PEDAL_UP) &&
                    ((in_ch.operation > OP_STOP) || ({1'b0, in_ch.note} < 8'(NOTES)));
  assign out_busy = out_valid_r && !out_ch.ready;
  assign scan_issue = rd_idx_r < VCW'(VOICES);
  assign apply_go = !(hold_vld_r && out_busy);
  assign age      = stamp_r - vm_rd.stamp;
  assign sust_bit = sust_q_r && sust_vq_r;
  assign vm_raddr = rd_idx_r[VAW-1:0];

  assign in_ch.ready         = (state_r == ST_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.voice        = out_r.voice;
  assign out_ch.action       = out_r.action;
  assign out_ch.note_out     = out_r.note;
  assign out_ch.velocity_out = out_r.velocity;
  assign out_ch.last         = out_last_r;

  // voice choice for the apply step
  always_comb begin
    has_res = 1'b0;
    sel_idx = match_idx_r;
    sel_act = ACT_RELEASE;
    case (op_r)
      OP_NOTE_ON: begin
        has_res = 1'b1;
        if (match_vld_r) begin
          sel_idx = match_idx_r;
          sel_act = ACT_RETRIG;
        end else if (free_vld_r) begin
          sel_idx = free_idx_r;
          sel_act = ACT_START;
        end else if (rel_vld_r) begin
          sel_idx = rel_idx_r;
          sel_act = ACT_STEAL_REL;
        end else begin
          // all ages zero falls back to voice 0
          sel_idx = all_vld_r ? all_idx_r : '0;
          sel_act = ACT_STEAL_OLD;
        end
      end
      OP_NOTE_OFF, OP_PEDAL_UP: begin
        has_res = match_vld_r;
        sel_act = ACT_RELEASE;
      end
      OP_STOP: begin
        has_res = match_vld_r;
        sel_act = ACT_STOP;
      end
      default: begin
        has_res = 1'b0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && acc_ok) begin
          case (in_ch.operation)
            OP_NOTE_ON, OP_STOP: state_nxt = ST_SCAN;
            OP_NOTE_OFF:         state_nxt = pedal_r ? ST_IDLE : ST_SCAN;
            OP_PEDAL_UP:         state_nxt = ST_SUST_RD;
            default:             state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SUST_RD: begin
        state_nxt = (sust_idx_r == SCW'(NOTES)) ? ST_FLUSH : ST_SUST_CHK;
      end
      ST_SUST_CHK: begin
        state_nxt = sust_bit ? ST_SCAN : ST_SUST_RD;
      end
      ST_SCAN: begin
        if (!scan_issue && !chk_vld_r) begin
          state_nxt = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (apply_go) begin
          state_nxt = (op_r == OP_PEDAL_UP) ? ST_SUST_RD : ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!hold_vld_r || !out_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    op_nxt        = op_r;
    vel_nxt       = vel_r;
    scan_note_nxt = scan_note_r;
    stamp_nxt     = stamp_r;
    pedal_nxt     = pedal_r;
    sust_idx_nxt  = sust_idx_r;
    rd_idx_nxt    = rd_idx_r;
    chk_vld_nxt   = 1'b0;
    chk_idx_nxt   = rd_idx_r[VAW-1:0];
    match_vld_nxt = match_vld_r;
    match_idx_nxt = match_idx_r;
    free_vld_nxt  = free_vld_r;
    free_idx_nxt  = free_idx_r;
    rel_vld_nxt   = rel_vld_r;
    rel_idx_nxt   = rel_idx_r;
    rel_age_nxt   = rel_age_r;
    all_vld_nxt   = all_vld_r;
    all_idx_nxt   = all_idx_r;
    all_age_nxt   = all_age_r;
    hold_vld_nxt  = hold_vld_r;
    hold_nxt      = hold_r;
    out_valid_nxt = out_busy;
    out_nxt       = out_r;
    out_last_nxt  = out_last_r;
    sust_we       = 1'b0;
    sust_wd       = 1'b0;
    sust_clr      = 1'b0;
    sust_waddr    = in_ch.note[SAW-1:0];
    sust_raddr    = sust_idx_r[SAW-1:0];
    vm_waddr      = sel_idx;
    vm_wr         = '0;

    case (state_r)
      ST_IDLE: begin
        // scan setup is harmless when no scan follows
        rd_idx_nxt    = '0;
        match_vld_nxt = 1'b0;
        free_vld_nxt  = 1'b0;
        rel_vld_nxt   = 1'b0;
        all_vld_nxt   = 1'b0;
        rel_age_nxt   = '0;
        all_age_nxt   = '0;
        if (in_fire && acc_ok) begin
          stamp_nxt     = stamp_r + 32'd1;
          op_nxt        = in_ch.operation;
          vel_nxt       = in_ch.velocity;
          scan_note_nxt = in_ch.note;
          sust_idx_nxt  = '0;
          case (in_ch.operation)
            OP_NOTE_ON: begin
              sust_we = 1'b1;
              sust_wd = 1'b0;
            end
            OP_NOTE_OFF: begin
              if (pedal_r) begin
                sust_we = 1'b1;
                sust_wd = 1'b1;
              end
            end
            OP_PEDAL_DOWN: pedal_nxt = 1'b1;
            default: ;
          endcase
        end
      end
      ST_SUST_RD: begin
        if (sust_idx_r == SCW'(NOTES)) begin
          sust_clr  = 1'b1;
          pedal_nxt = 1'b0;
        end
      end
      ST_SUST_CHK: begin
        if (sust_bit) begin
          scan_note_nxt = 7'(sust_idx_r);
          rd_idx_nxt    = '0;
          match_vld_nxt = 1'b0;
          free_vld_nxt  = 1'b0;
          rel_vld_nxt   = 1'b0;
          all_vld_nxt   = 1'b0;
          rel_age_nxt   = '0;
          all_age_nxt   = '0;
        end else begin
          sust_idx_nxt = sust_idx_r + SCW'(1);
        end
      end
      ST_SCAN: begin
        if (scan_issue) begin
          rd_idx_nxt  = rd_idx_r + VCW'(1);
          chk_vld_nxt = 1'b1;
        end
        if (chk_vld_r) begin
          if (!match_vld_r && vm_rd.note == {1'b0, scan_note_r}) begin
            match_vld_nxt = 1'b1;
            match_idx_nxt = chk_idx_r;
          end
          if (!free_vld_r && vm_rd.note[7]) begin
            free_vld_nxt = 1'b1;
            free_idx_nxt = chk_idx_r;
          end
          if (vm_rd.rel && age > rel_age_r) begin
            rel_vld_nxt = 1'b1;
            rel_idx_nxt = chk_idx_r;
            rel_age_nxt = age;
          end
          if (age > all_age_r) begin
            all_vld_nxt = 1'b1;
            all_idx_nxt = chk_idx_r;
            all_age_nxt = age;
          end
        end
      end
      ST_APPLY: begin
        if (apply_go) begin
          if (op_r == OP_PEDAL_UP) begin
            sust_idx_nxt = sust_idx_r + SCW'(1);
          end
          if (has_res) begin
            vm_wr.en        = 1'b1;
            vm_wr.ent.stamp = stamp_r;
            vm_wr.ent.note  = (op_r == OP_STOP) ? FREE_MARK : {1'b0, scan_note_r};
            vm_wr.ent.rel   = (sel_act == ACT_RELEASE);
            if (hold_vld_r) begin
              out_valid_nxt = 1'b1;
              out_nxt       = hold_r;
              out_last_nxt  = 1'b0;
            end
            hold_vld_nxt     = 1'b1;
            hold_nxt.voice   = 4'(sel_idx);
            hold_nxt.action  = sel_act;
            hold_nxt.note    = scan_note_r;
            hold_nxt.velocity = (op_r == OP_NOTE_ON) ? vel_r : 7'd0;
          end
        end
      end
      ST_FLUSH: begin
        if (hold_vld_r && !out_busy) begin
          out_valid_nxt = 1'b1;
          out_nxt       = hold_r;
          out_last_nxt  = 1'b1;
          hold_vld_nxt  = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      stamp_r     <= '0;
      pedal_r     <= 1'b0;
      chk_vld_r   <= 1'b0;
      hold_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      stamp_r     <= stamp_nxt;
      pedal_r     <= pedal_nxt;
      chk_vld_r   <= chk_vld_nxt;
      hold_vld_r  <= hold_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    vel_r       <= vel_nxt;
    scan_note_r <= scan_note_nxt;
    sust_idx_r  <= sust_idx_nxt;
    rd_idx_r    <= rd_idx_nxt;
    chk_idx_r   <= chk_idx_nxt;
    match_vld_r <= match_vld_nxt;
    match_idx_r <= match_idx_nxt;
    free_vld_r  <= free_vld_nxt;
    free_idx_r  <= free_idx_nxt;
    rel_vld_r   <= rel_vld_nxt;
    rel_idx_r   <= rel_idx_nxt;
    rel_age_r   <= rel_age_nxt;
    all_vld_r   <= all_vld_nxt;
    all_idx_r   <= all_idx_nxt;
    all_age_r   <= all_age_nxt;
    hold_r      <= hold_nxt;
    out_r       <= out_nxt;
    out_last_r  <= out_last_nxt;
  end

  // sustain memory: data array plus valid bits cleared at reset and pedal-up
  always_ff @(posedge clk) begin
    if (sust_we) begin
      sust_mem[sust_waddr] <= sust_wd;
    end
    sust_q_r <= sust_mem[sust_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sust_vld_r <= '0;
      sust_vq_r  <= 1'b0;
    end else begin
      if (sust_clr) begin
        sust_vld_r <= '0;
      end else if (sust_we) begin
        sust_vld_r[sust_waddr] <= 1'b1;
      end
      sust_vq_r <= sust_vld_r[sust_raddr];
    end
  end

  `PVA_ASSERT_ALWAYS(a_idle_no_hold, !(state_r == ST_IDLE && hold_vld_r), "result left in hold at idle")
  `PVA_ASSERT_NEXT(a_stamp_step, in_ch.valid && in_ch.ready && acc_ok, stamp_r == $past(stamp_r) + 32'd1, "stamp did not advance")
  `PVA_ASSERT_IMPL(a_pedal_up_done, state_r == ST_FLUSH && op_r == OP_PEDAL_UP, !pedal_r && sust_vld_r == '0, "pedal-up left sustain state")
  `PVA_ASSERT_IMPL(a_scan_bound, state_r == ST_SCAN, rd_idx_r <= VCW'(VOICES), "scan index past voice count")

endmodule

`default_nettype wire
